>>> src/xmevt_pkg.sv
package xmevt_pkg;

   localparam int PENDING_NOTES = 16;
   localparam int DELTA_BITS    = 28;
   localparam int PEND_IW       = (PENDING_NOTES > 1) ? $clog2(PENDING_NOTES) : 1;
   localparam int PEND_CW       = $clog2(PENDING_NOTES + 1);
   localparam logic [DELTA_BITS-1:0] DELTA_MAX = {DELTA_BITS{1'b1}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // command codes from front to back
   localparam logic [2:0] OP_PASS     = 3'd0;
   localparam logic [2:0] OP_PASS_FF  = 3'd1;
   localparam logic [2:0] OP_ZERO     = 3'd2;
   localparam logic [2:0] OP_ERR_STAT = 3'd3;
   localparam logic [2:0] OP_INTERVAL = 3'd4;
   localparam logic [2:0] OP_INSERT   = 3'd5;
   localparam logic [2:0] OP_EOT      = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_DELTA = 2'd0;
   localparam logic [1:0] KIND_OFF   = 2'd1;
   localparam logic [1:0] KIND_PASS  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_UNKNOWN = 2'd1;
   localparam logic [1:0] ERR_FULL    = 2'd2;

   localparam logic [7:0] BYTE_META     = 8'hFF;
   localparam logic [7:0] BYTE_EOT      = 8'h2F;
   localparam logic [7:0] BYTE_RUN      = 8'h7F;
   localparam logic [6:0] OFF_VELOCITY  = 7'h7F;

   typedef struct packed {
      logic [2:0]            op;
      logic                  owe;
      logic [7:0]            data;
      logic [DELTA_BITS-1:0] value;
      logic [3:0]            chan;
      logic [6:0]            key;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] vlq_bytes;
      logic [2:0]  vlq_length;
      logic [7:0]  off_status;
      logic [6:0]  off_key;
      logic [6:0]  off_velocity;
      logic [7:0]  pass_byte;
      logic [1:0]  error_code;
      logic        last;
   } res_type;

   // delta as VLQ, first byte sent in the low bits
   function automatic logic [34:0] vlq_encode(input logic [DELTA_BITS-1:0] v);
      logic [27:0] w;
      logic [6:0]  g0, g1, g2, g3;
      logic [31:0] bytes;
      logic [2:0]  len;
      w  = 28'(v);
      g0 = w[6:0];
      g1 = w[13:7];
      g2 = w[20:14];
      g3 = w[27:21];
      if (w[27:7] == '0) begin
         len   = 3'd1;
         bytes = {24'h0, 1'b0, g0};
      end else if (w[27:14] == '0) begin
         len   = 3'd2;
         bytes = {16'h0, 1'b0, g0, 1'b1, g1};
      end else if (w[27:21] == '0) begin
         len   = 3'd3;
         bytes = {8'h0, 1'b0, g0, 1'b1, g1, 1'b1, g2};
      end else begin
         len   = 3'd4;
         bytes = {1'b0, g0, 1'b1, g1, 1'b1, g2, 1'b1, g3};
      end
      return {len, bytes};
   endfunction

endpackage

>>> src/xmevt_front.sv
module xmevt_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_in_byte,
   input  logic                    q_full,
   output logic                    q_push,
   output xmevt_pkg::cmd_type      q_cmd
);

   localparam logic [3:0] PH_IDLE      = 4'd0;
   localparam logic [3:0] PH_INTERVAL  = 4'd1;
   localparam logic [3:0] PH_DATA      = 4'd2;
   localparam logic [3:0] PH_NOTE_KEY  = 4'd3;
   localparam logic [3:0] PH_NOTE_VEL  = 4'd4;
   localparam logic [3:0] PH_NOTE_DUR  = 4'd5;
   localparam logic [3:0] PH_META_TYPE = 4'd6;
   localparam logic [3:0] PH_META_LEN  = 4'd7;
   localparam logic [3:0] PH_META_BODY = 4'd8;

   localparam int DB = xmevt_pkg::DELTA_BITS;

   logic [3:0]    phase_ff, phase_in;
   logic [DB-1:0] ivl_ff, ivl_in;
   logic [DB-1:0] dur_ff, dur_in;
   logic          owe_ff, owe_in;
   logic [7:0]    status_ff, status_in;
   logic [7:0]    rem_ff, rem_in;
   logic [6:0]    key_ff, key_in;
   logic          ended_ff, ended_in;

   logic          accept;
   logic [DB:0]   ivl_sum;
   logic [DB+6:0] dur_shift;
   logic [DB-1:0] ivl_sat, dur_sat;
   logic [7:0]    b;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign b         = req_in_byte;

   assign ivl_sum   = {1'b0, ivl_ff} + (DB+1)'(b);
   assign ivl_sat   = ivl_sum[DB] ? xmevt_pkg::DELTA_MAX : ivl_sum[DB-1:0];
   assign dur_shift = {dur_ff, b[6:0]};
   assign dur_sat   = (dur_shift[DB+6:DB] != '0) ? xmevt_pkg::DELTA_MAX : dur_shift[DB-1:0];

   always_comb begin
      phase_in  = phase_ff;
      ivl_in    = ivl_ff;
      dur_in    = dur_ff;
      owe_in    = owe_ff;
      status_in = status_ff;
      rem_in    = rem_ff;
      key_in    = key_ff;
      ended_in  = ended_ff;
      q_push    = 1'b0;
      q_cmd     = '0;
      q_cmd.data  = b;
      q_cmd.chan  = status_ff[3:0];
      q_cmd.key   = key_ff;
      if (accept && !ended_ff) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!b[7]) begin
                  ivl_in = DB'(b);
                  if (b == xmevt_pkg::BYTE_RUN) begin
                     phase_in = PH_INTERVAL;
                  end else begin
                     q_push      = 1'b1;
                     q_cmd.op    = xmevt_pkg::OP_INTERVAL;
                     q_cmd.value = DB'(b);
                     owe_in      = 1'b0;
                     ivl_in      = '0;
                  end
               end else if (b == xmevt_pkg::BYTE_META) begin
                  q_push   = owe_ff;
                  q_cmd.op = xmevt_pkg::OP_ZERO;
                  owe_in   = 1'b1;
                  phase_in = PH_META_TYPE;
               end else if (b[7:4] != 4'hF) begin
                  q_push    = 1'b1;
                  q_cmd.op  = xmevt_pkg::OP_PASS;
                  q_cmd.owe = owe_ff;
                  owe_in    = 1'b1;
                  status_in = b;
                  if (b[7:4] == 4'h9) begin
                     phase_in = PH_NOTE_KEY;
                  end else begin
                     rem_in   = (b[7:4] == 4'hC || b[7:4] == 4'hD) ? 8'd1 : 8'd2;
                     phase_in = PH_DATA;
                  end
               end else begin
                  q_push   = 1'b1;
                  q_cmd.op = xmevt_pkg::OP_ERR_STAT;
               end
            end
            PH_INTERVAL: begin
               ivl_in = ivl_sat;
               if (b != xmevt_pkg::BYTE_RUN) begin
                  q_push      = 1'b1;
                  q_cmd.op    = xmevt_pkg::OP_INTERVAL;
                  q_cmd.value = ivl_sat;
                  owe_in      = 1'b0;
                  ivl_in      = '0;
                  phase_in    = PH_IDLE;
               end
            end
            PH_DATA, PH_META_BODY: begin
               q_push   = 1'b1;
               q_cmd.op = xmevt_pkg::OP_PASS;
               if (rem_ff != '0) rem_in = rem_ff - 8'd1;
               if (rem_ff <= 8'd1) phase_in = PH_IDLE;
            end
            PH_NOTE_KEY: begin
               q_push   = 1'b1;
               q_cmd.op = xmevt_pkg::OP_PASS;
               key_in   = b[6:0];
               phase_in = PH_NOTE_VEL;
            end
            PH_NOTE_VEL: begin
               q_push   = 1'b1;
               q_cmd.op = xmevt_pkg::OP_PASS;
               dur_in   = '0;
               phase_in = PH_NOTE_DUR;
            end
            PH_NOTE_DUR: begin
               dur_in = dur_sat;
               if (!b[7]) begin
                  q_push      = 1'b1;
                  q_cmd.op    = xmevt_pkg::OP_INSERT;
                  q_cmd.value = dur_sat;
                  phase_in    = PH_IDLE;
               end
            end
            PH_META_TYPE: begin
               q_push = 1'b1;
               if (b == xmevt_pkg::BYTE_EOT) begin
                  q_cmd.op = xmevt_pkg::OP_EOT;
                  ended_in = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  q_cmd.op = xmevt_pkg::OP_PASS_FF;
                  phase_in = PH_META_LEN;
               end
            end
            PH_META_LEN: begin
               q_push   = 1'b1;
               q_cmd.op = xmevt_pkg::OP_PASS;
               rem_in   = b;
               phase_in = (b != '0) ? PH_META_BODY : PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ivl_ff    <= '0;
         dur_ff    <= '0;
         owe_ff    <= 1'b1;
         status_ff <= '0;
         rem_ff    <= '0;
         key_ff    <= '0;
         ended_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ivl_ff    <= ivl_in;
         dur_ff    <= dur_in;
         owe_ff    <= owe_in;
         status_ff <= status_in;
         rem_ff    <= rem_in;
         key_ff    <= key_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

>>> src/xmevt_queue.sv
module xmevt_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  xmevt_pkg::cmd_type      push_cmd,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output xmevt_pkg::cmd_type      head_cmd
);

   localparam int IW = xmevt_pkg::QUEUE_IW;
   localparam int CW = xmevt_pkg::QUEUE_CW;

   xmevt_pkg::cmd_type slot_ff [xmevt_pkg::QUEUE_DEPTH];
   logic [IW-1:0] wr_ff, wr_in;
   logic [IW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full       = (cnt_ff == CW'(xmevt_pkg::QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? IW'((32'(wr_ff) + 1) % xmevt_pkg::QUEUE_DEPTH) : wr_ff;
      rd_in  = do_pop  ? IW'((32'(rd_ff) + 1) % xmevt_pkg::QUEUE_DEPTH) : rd_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_cmd;
   end

endmodule

>>> src/xmevt_back.sv
module xmevt_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  xmevt_pkg::cmd_type      q_cmd,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output xmevt_pkg::res_type      rsp
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PRE    = 4'd1;
   localparam logic [3:0] S_PASS   = 4'd2;
   localparam logic [3:0] S_FF     = 4'd3;
   localparam logic [3:0] S_ERR    = 4'd4;
   localparam logic [3:0] S_INS    = 4'd5;
   localparam logic [3:0] S_IV     = 4'd6;
   localparam logic [3:0] S_IV_OFF = 4'd7;
   localparam logic [3:0] S_E_OFF  = 4'd8;
   localparam logic [3:0] S_E_ZERO = 4'd9;
   localparam logic [3:0] S_E_2F   = 4'd10;
   localparam logic [3:0] S_E_00   = 4'd11;

   localparam logic [2:0] T_NONE    = 3'd0;
   localparam logic [2:0] T_INS     = 3'd1;
   localparam logic [2:0] T_POP_SUB = 3'd2;
   localparam logic [2:0] T_POP     = 3'd3;
   localparam logic [2:0] T_SUB     = 3'd4;

   localparam int N  = xmevt_pkg::PENDING_NOTES;
   localparam int DB = xmevt_pkg::DELTA_BITS;
   localparam int CW = xmevt_pkg::PEND_CW;

   logic [3:0]         state_ff, state_in;
   xmevt_pkg::cmd_type cmd_ff, cmd_in;
   logic [DB-1:0]      rem_ff, rem_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [DB-1:0]      delta_ff [N];
   logic [3:0]         chan_ff  [N];
   logic [6:0]         key_ff   [N];
   logic               rsp_valid_ff, rsp_valid_in;
   xmevt_pkg::res_type rsp_ff;

   logic               can_emit, emit, full;
   xmevt_pkg::res_type res;
   logic [2:0]         tbl_op;
   logic [N-1:0]       le_dur;
   logic [CW-1:0]      ins_pos;

   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign full     = (cnt_ff == CW'(N));
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // insert position: entries kept ahead of the new note
   always_comb begin
      for (int i = 0; i < N; i++) begin
         le_dur[i] = (CW'(i) < cnt_ff) && (delta_ff[i] <= cmd_ff.value);
      end
      ins_pos = CW'($countones(le_dur));
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      tbl_op   = T_NONE;
      res      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               rem_in = q_cmd.value;
               unique case (q_cmd.op)
                  xmevt_pkg::OP_PASS:     state_in = q_cmd.owe ? S_PRE : S_PASS;
                  xmevt_pkg::OP_PASS_FF:  state_in = S_FF;
                  xmevt_pkg::OP_ZERO:     state_in = S_PRE;
                  xmevt_pkg::OP_ERR_STAT: state_in = S_ERR;
                  xmevt_pkg::OP_INTERVAL: state_in = S_IV;
                  xmevt_pkg::OP_INSERT:   state_in = S_INS;
                  xmevt_pkg::OP_EOT:      state_in = S_E_OFF;
                  default:                state_in = S_IDLE;
               endcase
            end
         end
         S_PRE: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_DELTA;
               {res.vlq_length, res.vlq_bytes} = xmevt_pkg::vlq_encode('0);
               res.last = (cmd_ff.op == xmevt_pkg::OP_ZERO);
               state_in = res.last ? S_IDLE : S_PASS;
            end
         end
         S_PASS: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_PASS;
               res.pass_byte = cmd_ff.data;
               res.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FF: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_PASS;
               res.pass_byte = xmevt_pkg::BYTE_META;
               state_in = S_PASS;
            end
         end
         S_ERR: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_ERROR;
               res.error_code = xmevt_pkg::ERR_UNKNOWN;
               res.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INS: begin
            if (full) begin
               if (can_emit) begin
                  emit = 1'b1;
                  res.kind = xmevt_pkg::KIND_ERROR;
                  res.error_code = xmevt_pkg::ERR_FULL;
                  res.last = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               tbl_op   = T_INS;
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_IDLE;
            end
         end
         S_IV: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_DELTA;
               if (cnt_ff != '0 && rem_ff > delta_ff[0]) begin
                  {res.vlq_length, res.vlq_bytes} = xmevt_pkg::vlq_encode(delta_ff[0]);
                  state_in = S_IV_OFF;
               end else begin
                  {res.vlq_length, res.vlq_bytes} = xmevt_pkg::vlq_encode(rem_ff);
                  res.last = 1'b1;
                  tbl_op   = T_SUB;
                  state_in = S_IDLE;
               end
            end
         end
         S_IV_OFF: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_OFF;
               res.off_status = {4'h8, chan_ff[0]};
               res.off_key = key_ff[0];
               res.off_velocity = xmevt_pkg::OFF_VELOCITY;
               tbl_op   = T_POP_SUB;
               cnt_in   = cnt_ff - CW'(1);
               rem_in   = rem_ff - delta_ff[0];
               state_in = S_IV;
            end
         end
         S_E_OFF: begin
            if (can_emit) begin
               emit = 1'b1;
               if (cnt_ff != '0) begin
                  res.kind = xmevt_pkg::KIND_OFF;
                  res.off_status = {4'h8, chan_ff[0]};
                  res.off_key = key_ff[0];
                  res.off_velocity = xmevt_pkg::OFF_VELOCITY;
                  tbl_op   = T_POP;
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = S_E_ZERO;
               end else begin
                  res.kind = xmevt_pkg::KIND_PASS;
                  res.pass_byte = xmevt_pkg::BYTE_META;
                  state_in = S_E_2F;
               end
            end
         end
         S_E_ZERO: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_DELTA;
               {res.vlq_length, res.vlq_bytes} = xmevt_pkg::vlq_encode('0);
               state_in = S_E_OFF;
            end
         end
         S_E_2F: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_PASS;
               res.pass_byte = xmevt_pkg::BYTE_EOT;
               state_in = S_E_00;
            end
         end
         S_E_00: begin
            if (can_emit) begin
               emit = 1'b1;
               res.kind = xmevt_pkg::KIND_PASS;
               res.pass_byte = 8'h00;
               res.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rem_ff <= rem_in;
      if (emit) rsp_ff <= res;
   end

   // pending table, kept sorted with the earliest note-off at entry 0
   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         unique case (tbl_op)
            T_INS: begin
               if (CW'(i) == ins_pos) begin
                  delta_ff[i] <= cmd_ff.value;
                  chan_ff[i]  <= cmd_ff.chan;
                  key_ff[i]   <= cmd_ff.key;
               end else if (CW'(i) > ins_pos && i > 0) begin
                  delta_ff[i] <= delta_ff[(i > 0) ? i - 1 : 0];
                  chan_ff[i]  <= chan_ff[(i > 0) ? i - 1 : 0];
                  key_ff[i]   <= key_ff[(i > 0) ? i - 1 : 0];
               end
            end
            T_POP_SUB, T_POP: begin
               if (i < N - 1) begin
                  delta_ff[i] <= (tbl_op == T_POP_SUB)
                                 ? delta_ff[(i < N - 1) ? i + 1 : i] - delta_ff[0]
                                 : delta_ff[(i < N - 1) ? i + 1 : i];
                  chan_ff[i]  <= chan_ff[(i < N - 1) ? i + 1 : i];
                  key_ff[i]   <= key_ff[(i < N - 1) ? i + 1 : i];
               end
            end
            T_SUB: begin
               delta_ff[i] <= delta_ff[i] - rem_ff;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

>>> src/xmidi_event_to_midi_note_off_scheduler_unit.sv
// xmidi event chunk to standard midi event stream
// req channel: one byte of the event chunk per item on req_in_byte, taken
//   when req_valid is high and req_stall low
// rsp channel: one result item per accepted handshake; rsp_last_of_run marks
//   the final result caused by a byte, bytes that cause nothing give no item
// path: a byte is parsed in the cycle it is taken; its command is written
//   into the command queue, popped into the back's command register, and
//   its results are registered in the output stage
// throughput: the front takes one byte a cycle while the 4-entry command
//   queue has room; the back sequencer fetches a command and then emits its
//   results one at a time as the output takes them, and fetches no new
//   command until the last result of the current one has been emitted
// rsp_stall holds the output register; the back waits, the queue fills and
//   then req_stall rises, nothing is lost
// reset clears the parser, the queue, the pending count and the output valid;
//   the pending table itself needs no clearing
module xmidi_event_to_midi_note_off_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_emit_kind,
   output logic [31:0] rsp_vlq_bytes,
   output logic [2:0]  rsp_vlq_length,
   output logic [7:0]  rsp_off_status,
   output logic [6:0]  rsp_off_key,
   output logic [6:0]  rsp_off_velocity,
   output logic [7:0]  rsp_pass_byte,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last_of_run
);

   // front to queue
   logic               push;
   xmevt_pkg::cmd_type push_cmd;
   logic               q_full;
   // queue to back
   logic               pop;
   logic               head_valid;
   xmevt_pkg::cmd_type head_cmd;
   // result register
   xmevt_pkg::res_type res;

   // parser: phase, interval and duration sums, zero-delta owed flag
   xmevt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (push),
      .q_cmd       (push_cmd)
   );

   // short command queue decoupling parse from scheduling
   xmevt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // sequencer owning the sorted pending note-off table and the output stage
   xmevt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_cmd     (head_cmd),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (res)
   );

   assign rsp_emit_kind    = res.kind;
   assign rsp_vlq_bytes    = res.vlq_bytes;
   assign rsp_vlq_length   = res.vlq_length;
   assign rsp_off_status   = res.off_status;
   assign rsp_off_key      = res.off_key;
   assign rsp_off_velocity = res.off_velocity;
   assign rsp_pass_byte    = res.pass_byte;
   assign rsp_error_code   = res.error_code;
   assign rsp_last_of_run  = res.last;

endmodule
